/* src/qpvt_pkg.sv */
// ----------------------------------------------------------------------------
// Quadrature tracker package
// Shared widths, register map, reset values and scaling constants.
// ----------------------------------------------------------------------------
package qpvt_pkg;

   localparam int COUNTER_BITS_DEF  = 16;
   localparam int POSITION_BITS_DEF = 48;

   localparam int CNT_W  = 16;
   localparam int TIME_W = 32;
   localparam int OUT_W  = 48;
   localparam int CFG_W  = 16;
   localparam int APB_DW = 32;
   localparam int APB_AW = 4;

   localparam logic [1:0] REG_COUNTER_TOP = 2'd0;
   localparam logic [1:0] REG_LINES       = 2'd1;
   localparam logic [1:0] REG_GEAR        = 2'd2;

   localparam logic [CFG_W-1:0] COUNTER_TOP_RST = 16'd65535;
   localparam logic [CFG_W-1:0] LINES_RST       = 16'd100;
   localparam logic [CFG_W-1:0] GEAR_RST        = 16'd12800;

   localparam int K_W       = 16;
   localparam int FRAC_SHIFT = 22;
   localparam logic [K_W-1:0] VEL_K = 16'd60000;
   localparam logic [K_W-1:0] ANG_K = 16'd360;

endpackage

/* src/qpvt_if.sv */
// ----------------------------------------------------------------------------
// Quadrature tracker channels
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface qpvt_req_if import qpvt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [CNT_W-1:0]  counter_value;
   logic [TIME_W-1:0] now_ms;
   modport source (output valid, mode, counter_value, now_ms, input ready);
   modport sink   (input valid, mode, counter_value, now_ms, output ready);
endinterface

interface qpvt_rsp_if import qpvt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] position_count;
   logic signed [OUT_W-1:0] angle_deg_q16;
   logic signed [OUT_W-1:0] velocity_rpm_q16;
   logic                    velocity_updated;
   modport source (output valid, position_count, angle_deg_q16, velocity_rpm_q16,
                   velocity_updated, input ready);
   modport sink   (input valid, position_count, angle_deg_q16, velocity_rpm_q16,
                   velocity_updated, output ready);
endinterface

/* src/quadrature_position_velocity_tracker_top.sv */
// ----------------------------------------------------------------------------
// Quadrature position and velocity tracker
// Unwraps encoder counter samples into a saturating position and derives
// output shaft angle and speed with one shared restoring divider.
// ----------------------------------------------------------------------------
//   channel  direction  word
//   req      in         mode, counter_value, now_ms
//   rsp      out        position_count, angle_deg_q16, velocity_rpm_q16, updated
//   csr      in/out     APB registers counter_top, lines_per_rev, gear_ratio_q8
//
// A sample that updates the speed runs the one-bit-per-cycle divider for speed
// and then for angle; a sample without a speed update runs it for angle only.
// A zero ratio or line count skips the divider, and a reset request goes
// straight to the result. Reset is synchronous; it clears the state, position,
// time and speed tracking and the output valid and reloads register defaults.
// A stalled result holds in the output register; the next word is taken once
// the previous result has been loaded there.
// ----------------------------------------------------------------------------
module quadrature_position_velocity_tracker_top import qpvt_pkg::*; #(
   parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   qpvt_req_if.sink          req,
   qpvt_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [APB_AW-1:0] csr_paddr,
   input  logic [APB_DW-1:0] csr_pwdata,
   output logic [APB_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int PB  = POSITION_BITS;
   localparam int PW  = PB + K_W;
   localparam int NW  = PW + FRAC_SHIFT;
   localparam int DW  = 2 * TIME_W;
   localparam int ITW = $clog2(NW);
   localparam logic [CNT_W-1:0] CNT_MASK = (COUNTER_BITS >= CNT_W) ? {CNT_W{1'b1}} :
                                           CNT_W'((32'd1 << COUNTER_BITS) - 32'd1);
   localparam logic [OUT_W-1:0] LIM_POS = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] LIM_NEG = {1'b1, {(OUT_W-1){1'b0}}};

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_VEL   = 3'd2;
   localparam logic [2:0] S_APREP = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]              state_ff;
   logic [CFG_W-1:0]        top_ff, lines_ff, gear_ff;
   logic [CNT_W-1:0]        cnt_ff, last_ff;
   logic [TIME_W-1:0]       now_ff, tl_ff, dt_ff;
   logic signed [PB-1:0]    pos_ff, pal_ff;
   logic signed [OUT_W-1:0] speed_ff, angle_ff;
   logic                    upd_ff, neg_ff, phase_ff;
   logic [2*CFG_W-1:0]      denom_ff;
   logic [PB-1:0]           mag_ff;
   logic [K_W-1:0]          k_ff;
   logic [DW-1:0]           dv_ff, rem_ff;
   logic [NW-1:0]           num_ff, quot_ff;
   logic [ITW-1:0]          it_ff;
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] out_pos_ff, out_ang_ff, out_spd_ff;
   logic                    out_upd_ff;

   logic                    cfg_wr;
   logic signed [17:0]      diff_raw, half, period, diff;
   logic signed [PB:0]      sum;
   logic signed [63:0]      pos_wide;
   logic [DW:0]             shifted, rem_in;
   logic                    ge;
   logic [NW-1:0]           quot_in;
   logic [OUT_W-1:0]        q_sat, div_res;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_COUNTER_TOP: csr_prdata = {16'd0, top_ff};
         REG_LINES:       csr_prdata = {16'd0, lines_ff};
         REG_GEAR:        csr_prdata = {16'd0, gear_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      diff_raw = $signed({2'b00, cnt_ff}) - $signed({2'b00, last_ff});
      half     = $signed({3'b000, top_ff[CFG_W-1:1]});
      period   = $signed({2'b00, top_ff}) + 18'sd1;
      if (diff_raw > half) begin
         diff = diff_raw - period;
      end else if (diff_raw < -half) begin
         diff = diff_raw + period;
      end else begin
         diff = diff_raw;
      end
      sum = $signed({pos_ff[PB-1], pos_ff}) + (PB+1)'(diff);
   end

   always_comb begin
      shifted = {rem_ff, num_ff[NW-1]};
      ge      = shifted >= {1'b0, dv_ff};
      rem_in  = ge ? (shifted - {1'b0, dv_ff}) : shifted;
      quot_in = {quot_ff[NW-2:0], ge};
      if (neg_ff) begin
         q_sat = (quot_in > NW'(LIM_NEG)) ? LIM_NEG : quot_in[OUT_W-1:0];
      end else begin
         q_sat = (quot_in > NW'(LIM_POS)) ? LIM_POS : quot_in[OUT_W-1:0];
      end
      div_res = neg_ff ? (~q_sat + 48'd1) : q_sat;
   end

   assign pos_wide = 64'(pos_ff);
   assign req.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= COUNTER_TOP_RST;
         lines_ff     <= LINES_RST;
         gear_ff      <= GEAR_RST;
         last_ff      <= '0;
         pos_ff       <= '0;
         pal_ff       <= '0;
         tl_ff        <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            unique case (csr_paddr[3:2])
               REG_COUNTER_TOP: top_ff   <= csr_pwdata[CFG_W-1:0];
               REG_LINES:       lines_ff <= csr_pwdata[CFG_W-1:0];
               REG_GEAR:        gear_ff  <= csr_pwdata[CFG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  cnt_ff <= req.counter_value & CNT_MASK;
                  now_ff <= req.now_ms;
                  upd_ff <= 1'b0;
                  if (req.mode) begin
                     pos_ff   <= '0;
                     pal_ff   <= '0;
                     speed_ff <= '0;
                     angle_ff <= '0;
                     last_ff  <= '0;
                     tl_ff    <= req.now_ms;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_PREP;
                  end
               end
            end
            S_PREP: begin
               denom_ff <= lines_ff * gear_ff;
               dt_ff    <= now_ff - tl_ff;
               last_ff  <= cnt_ff;
               if (sum[PB] != sum[PB-1]) begin
                  pos_ff <= sum[PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
               end else begin
                  pos_ff <= sum[PB-1:0];
               end
               state_ff <= S_VEL;
            end
            S_VEL: begin
               state_ff <= S_APREP;
               if (dt_ff >= 32'd2) begin
                  upd_ff <= 1'b1;
                  pal_ff <= pos_ff;
                  tl_ff  <= now_ff;
                  if (denom_ff == '0) begin
                     speed_ff <= '0;
                  end else begin
                     neg_ff   <= pos_ff < pal_ff;
                     mag_ff   <= (pos_ff < pal_ff) ? PB'(pal_ff - pos_ff) : PB'(pos_ff - pal_ff);
                     k_ff     <= VEL_K;
                     dv_ff    <= denom_ff * dt_ff;
                     phase_ff <= 1'b0;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_APREP: begin
               if (denom_ff == '0) begin
                  angle_ff <= '0;
                  state_ff <= S_DONE;
               end else begin
                  neg_ff   <= pos_ff < 0;
                  mag_ff   <= (pos_ff < 0) ? PB'(-pos_ff) : PB'(pos_ff);
                  k_ff     <= ANG_K;
                  dv_ff    <= DW'(denom_ff);
                  phase_ff <= 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               num_ff   <= {PW'(PW'(mag_ff) * PW'(k_ff)), {FRAC_SHIFT{1'b0}}};
               rem_ff   <= '0;
               quot_ff  <= '0;
               it_ff    <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= rem_in[DW-1:0];
               quot_ff <= quot_in;
               num_ff  <= {num_ff[NW-2:0], 1'b0};
               it_ff   <= it_ff + 1'b1;
               if (it_ff == ITW'(NW - 1)) begin
                  if (phase_ff) begin
                     angle_ff <= div_res;
                     state_ff <= S_DONE;
                  end else begin
                     speed_ff <= div_res;
                     state_ff <= S_APREP;
                  end
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  out_pos_ff   <= pos_wide[OUT_W-1:0];
                  out_ang_ff   <= angle_ff;
                  out_spd_ff   <= speed_ff;
                  out_upd_ff   <= upd_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (rsp_valid_ff && rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.position_count   = out_pos_ff;
   assign rsp.angle_deg_q16    = out_ang_ff;
   assign rsp.velocity_rpm_q16 = out_spd_ff;
   assign rsp.velocity_updated = out_upd_ff;

endmodule
